// ----- src/assert_macros.svh -----
// assertion helpers used by the checker file pqt_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, skipped while reset is high
`define CHK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("check failed");

// property checked on every rising edge, reset included
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("check failed");

`endif

// ----- src/pqt_pkg.sv -----
`default_nettype none

package pqt_pkg;

   // default sizes
   localparam int QUEUE_DEPTH_DEF   = 16;
   localparam int KEY_BITS_DEF      = 16;
   localparam int PRIORITY_BITS_DEF = 8;

   // action codes carried on req_tuser
   localparam int ACTION_BITS = 2;
   localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_POP    = 2'd2;

   // status codes carried on rsp_tuser
   localparam int STATUS_BITS = 3;
   localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_DUP     = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_MISSING = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd4;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_REDUCE,
      S_UPDATE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic compare;
      logic reduce;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_busy;
   } sts_type;

endpackage

`default_nettype wire

// ----- src/pqt_ctrl.sv -----
`default_nettype none

module pqt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  pqt_pkg::sts_type sts,
   output pqt_pkg::cmd_type cmd
);
   import pqt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = S_REDUCE;
         end
         S_REDUCE: begin
            cmd.reduce = 1'b1;
            state_in   = S_UPDATE;
         end
         S_UPDATE: begin
            // hold until the output register can take the result
            if (!sts.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- src/pqt_datapath.sv -----
`default_nettype none

module pqt_datapath #(
   parameter int QUEUE_DEPTH   = pqt_pkg::QUEUE_DEPTH_DEF,
   parameter int KEY_BITS      = pqt_pkg::KEY_BITS_DEF,
   parameter int PRIORITY_BITS = pqt_pkg::PRIORITY_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [pqt_pkg::ACTION_BITS-1:0] in_action,
   input  logic [KEY_BITS-1:0]             in_key,
   input  logic [PRIORITY_BITS-1:0]        in_prio,
   input  pqt_pkg::cmd_type                cmd,
   output pqt_pkg::sts_type                sts,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [pqt_pkg::STATUS_BITS-1:0] out_status,
   output logic [KEY_BITS-1:0]             out_key,
   output logic [PRIORITY_BITS-1:0]        out_prio
);
   import pqt_pkg::*;

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // latched request
   logic [ACTION_BITS-1:0]   act_ff;
   logic [KEY_BITS-1:0]      key_ff;
   logic [PRIORITY_BITS-1:0] prio_ff;

   // sorted list, head at index 0
   logic [KEY_BITS-1:0]      ent_key_ff  [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0] ent_prio_ff [QUEUE_DEPTH];
   logic [KEY_BITS-1:0]      ent_key_in  [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0] ent_prio_in [QUEUE_DEPTH];
   logic [KEY_BITS-1:0]      up_key      [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0] up_prio     [QUEUE_DEPTH];
   logic [KEY_BITS-1:0]      dn_key      [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0] dn_prio     [QUEUE_DEPTH];
   logic [CNT_BITS-1:0]      count_ff, count_in;

   // per-entry flags
   logic [QUEUE_DEPTH-1:0] match_ff, match_in;
   logic [QUEUE_DEPTH-1:0] after_ff, after_in;
   logic [QUEUE_DEPTH-1:0] kill_ff, kill_in;
   logic [QUEUE_DEPTH-1:0] ins_here, del_vec;
   logic                   any_ff, any_in;

   // decision
   logic                     do_ins, do_del;
   logic [STATUS_BITS-1:0]   status_in;
   logic [KEY_BITS-1:0]      served_key_in;
   logic [PRIORITY_BITS-1:0] served_prio_in;

   // output register
   logic                     out_valid_ff;
   logic [STATUS_BITS-1:0]   out_status_ff;
   logic [KEY_BITS-1:0]      out_key_ff;
   logic [PRIORITY_BITS-1:0] out_prio_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= in_action;
         key_ff  <= in_key;
         prio_ff <= in_prio;
      end
   end

   // compare against every stored entry; list stays non-increasing, so the
   // insert flags form one run from the insert point to the end
   always_comb begin
      logic head_gt;
      logic valid;
      head_gt = (count_ff == '0) || (prio_ff > ent_prio_ff[0]);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         valid       = CNT_BITS'(i) < count_ff;
         match_in[i] = valid && (ent_key_ff[i] == key_ff);
         after_in[i] = head_gt ||
                       ((i != 0) && (!valid || (prio_ff >= ent_prio_ff[i])));
      end
   end

   // keys are unique, so one match at most; kill marks it and all after it
   always_comb begin
      logic [QUEUE_DEPTH-1:0] v;
      v = match_ff;
      for (int s = 1; s < QUEUE_DEPTH; s = s * 2) begin
         v = v | (v << s);
      end
      kill_in = v;
      any_in  = |match_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         match_ff <= match_in;
         after_ff <= after_in;
      end
      if (cmd.reduce) begin
         kill_ff <= kill_in;
         any_ff  <= any_in;
      end
   end

   always_comb begin
      do_ins         = 1'b0;
      do_del         = 1'b0;
      del_vec        = kill_ff;
      status_in      = ST_OK;
      served_key_in  = '0;
      served_prio_in = '0;
      unique case (act_ff)
         ACT_INSERT: begin
            if (any_ff) begin
               status_in = ST_DUP;
            end else if (count_ff == CNT_BITS'(QUEUE_DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         ACT_REMOVE: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else if (!any_ff) begin
               status_in = ST_MISSING;
            end else begin
               do_del = 1'b1;
            end
         end
         ACT_POP: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               do_del         = 1'b1;
               del_vec        = '1;
               served_key_in  = ent_key_ff[0];
               served_prio_in = ent_prio_ff[0];
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // neighbor taps for shifting down (insert) and up (delete)
   always_comb begin
      up_key[0]  = key_ff;
      up_prio[0] = prio_ff;
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
         up_key[i]  = ent_key_ff[i-1];
         up_prio[i] = ent_prio_ff[i-1];
      end
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         dn_key[i]  = ent_key_ff[i+1];
         dn_prio[i] = ent_prio_ff[i+1];
      end
      dn_key[QUEUE_DEPTH-1]  = ent_key_ff[QUEUE_DEPTH-1];
      dn_prio[QUEUE_DEPTH-1] = ent_prio_ff[QUEUE_DEPTH-1];
   end

   assign ins_here = after_ff & ~{after_ff[QUEUE_DEPTH-2:0], 1'b0};

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ent_key_in[i]  = ent_key_ff[i];
         ent_prio_in[i] = ent_prio_ff[i];
         if (cmd.commit && do_ins && ins_here[i]) begin
            ent_key_in[i]  = key_ff;
            ent_prio_in[i] = prio_ff;
         end else if (cmd.commit && do_ins && after_ff[i]) begin
            ent_key_in[i]  = up_key[i];
            ent_prio_in[i] = up_prio[i];
         end else if (cmd.commit && do_del && del_vec[i]) begin
            ent_key_in[i]  = dn_key[i];
            ent_prio_in[i] = dn_prio[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ent_key_ff[i]  <= ent_key_in[i];
         ent_prio_ff[i] <= ent_prio_in[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.commit && do_ins) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (cmd.commit && do_del) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.commit) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_status_ff <= status_in;
         out_key_ff    <= served_key_in;
         out_prio_ff   <= served_prio_in;
      end
   end

   assign sts.out_busy = out_valid_ff && !out_ready;
   assign out_valid    = out_valid_ff;
   assign out_status   = out_status_ff;
   assign out_key      = out_key_ff;
   assign out_prio     = out_prio_ff;

endmodule

`default_nettype wire

// ----- src/priority_task_queue.sv -----
// priority_task_queue: bounded list of tasks kept in descending priority order
// req channel: req_tuser = action (insert, remove by key, pop head),
//   req_tdata = task key and task priority; one transfer is one request
// rsp channel: exactly one transfer per request, in request order;
//   rsp_tuser = status, rsp_tdata = served key and priority (zero unless a
//   successful pop)
// result path: rsp_tvalid rises once the update step commits, after the request
//   has gone through compare all entries, reduce match flags, update list
// one request at a time: req_tready is high only in idle, so a new request is
//   taken only after the compare / reduce / update sequence of the last one
// stalls: a finished result waits in the output register; the next request
//   is still taken and processed, but its update waits until rsp frees up
// reset: list empty, no result pending, ready for a request next cycle
// queue entries hold no reset value; only entries below the count are used
`default_nettype none

module priority_task_queue #(
   parameter int QUEUE_DEPTH   = pqt_pkg::QUEUE_DEPTH_DEF,
   parameter int KEY_BITS      = pqt_pkg::KEY_BITS_DEF,
   parameter int PRIORITY_BITS = pqt_pkg::PRIORITY_BITS_DEF,
   localparam int DATA_BITS    = ((KEY_BITS + PRIORITY_BITS + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [DATA_BITS-1:0]            req_tdata,  // task_key, task_priority, zero pad
   input  logic [pqt_pkg::ACTION_BITS-1:0] req_tuser,  // action
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [DATA_BITS-1:0]            rsp_tdata,  // served_key, served_priority, zero pad
   output logic [pqt_pkg::STATUS_BITS-1:0] rsp_tuser   // status
);
   import pqt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   logic [KEY_BITS-1:0]      rsp_key;
   logic [PRIORITY_BITS-1:0] rsp_prio;

   // sequencer: one request at a time through compare, reduce, update
   pqt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // entry row, per-entry compare and shift, output register
   pqt_datapath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .KEY_BITS      (KEY_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .in_action  (req_tuser),
      .in_key     (req_tdata[KEY_BITS-1:0]),
      .in_prio    (req_tdata[KEY_BITS+PRIORITY_BITS-1:KEY_BITS]),
      .cmd        (cmd),
      .sts        (sts),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (rsp_tuser),
      .out_key    (rsp_key),
      .out_prio   (rsp_prio)
   );

   // pack the served fields, key in the low bits
   assign rsp_tdata = DATA_BITS'({rsp_prio, rsp_key});

endmodule

`default_nettype wire

// ----- src/pqt_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module pqt_checker #(
   parameter int KEY_BITS      = pqt_pkg::KEY_BITS_DEF,
   parameter int PRIORITY_BITS = pqt_pkg::PRIORITY_BITS_DEF,
   localparam int DATA_BITS    = ((KEY_BITS + PRIORITY_BITS + 7) / 8) * 8
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [DATA_BITS-1:0]            req_tdata,
   input logic [pqt_pkg::ACTION_BITS-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [DATA_BITS-1:0]            rsp_tdata,
   input logic [pqt_pkg::STATUS_BITS-1:0] rsp_tuser
);
   import pqt_pkg::*;

   logic                               req_xfer;
   logic                               req_stall;
   logic                               rsp_stall;
   logic [DATA_BITS+ACTION_BITS-1:0]   req_word;
   logic [DATA_BITS+STATUS_BITS-1:0]   rsp_word;

   assign req_xfer  = req_tvalid && req_tready;
   assign req_stall = req_tvalid && !req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_word  = {req_tuser, req_tdata};
   assign rsp_word  = {rsp_tuser, rsp_tdata};

   // stalled request holds
   `CHK_ASSERT(a_req_hold, clock, reset, req_stall |=> req_tvalid && $stable(req_word))
   // stalled result holds
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_word))
   // served fields are zero unless the status is ok
   `CHK_ASSERT(a_served_zero, clock, reset, rsp_tvalid && (rsp_tuser != ST_OK) |-> (rsp_tdata == '0))
   // one request in flight: not ready right after a transfer
   `CHK_ASSERT(a_busy_after_req, clock, reset, req_xfer |=> !req_tready)
   // reset leaves no result pending
   `CHK_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_tvalid)

endmodule

bind priority_task_queue pqt_checker #(
   .KEY_BITS      (KEY_BITS),
   .PRIORITY_BITS (PRIORITY_BITS)
) u_pqt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
